/* sv/hsl2rgb_pkg.sv */
`default_nettype none

package hsl2rgb_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int IN_W          = 17;
   localparam int OUT_W         = 8;
   localparam int INT_BITS      = 30;
   localparam int FX_W          = INT_BITS + 1;
   localparam int SHIFT_IN      = INT_BITS - FRACTION_BITS;
   localparam int PROD_W        = 2 * FX_W;
   localparam int SCALE_W       = FX_W + 9;

   localparam logic [31:0]     IN_ONE        = 32'(64'd1 << FRACTION_BITS);
   localparam logic [FX_W-1:0] FX_ONE        = FX_W'(64'd1 << INT_BITS);
   localparam logic [FX_W-1:0] FX_HALF       = FX_W'((64'd1 << INT_BITS) / 2);
   localparam logic [FX_W-1:0] FX_THIRD      = FX_W'((64'd1 << INT_BITS) / 3);
   localparam logic [FX_W-1:0] FX_SIXTH      = FX_W'((64'd1 << INT_BITS) / 6);
   localparam logic [FX_W-1:0] FX_TWO_THIRDS = FX_W'((64'd2 << INT_BITS) / 3);

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [IN_W-1:0] hue;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] lightness;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rsp_type;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_Q,
      SEG_FALL,
      SEG_P
   } seg_type;

   typedef struct packed {
      seg_type         seg;
      logic [FX_W-1:0] x;
   } chan_type;

   typedef struct packed {
      logic [FX_W-1:0] p;
      logic [FX_W-1:0] d;
      chan_type [2:0]  chan;
   } mid_type;

endpackage

`default_nettype wire

/* sv/hsl2rgb_front.sv */
`default_nettype none

module hsl2rgb_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   output logic                    full,
   input  hsl2rgb_pkg::req_type    req_data,
   output logic                    mid_push,
   input  wire                     mid_full,
   output hsl2rgb_pkg::mid_type    mid_data
);

   function automatic logic [hsl2rgb_pkg::FX_W-1:0] widen(
      input logic [hsl2rgb_pkg::IN_W-1:0] raw);
      logic [31:0] v;
      begin
         v = 32'(raw);
         if (v > hsl2rgb_pkg::IN_ONE) v = hsl2rgb_pkg::IN_ONE;
         widen = hsl2rgb_pkg::FX_W'(v << hsl2rgb_pkg::SHIFT_IN);
      end
   endfunction

   function automatic hsl2rgb_pkg::chan_type classify(
      input logic [hsl2rgb_pkg::FX_W-1:0] t);
      hsl2rgb_pkg::chan_type r;
      logic [hsl2rgb_pkg::FX_W-1:0] y;
      begin
         y = hsl2rgb_pkg::FX_TWO_THIRDS - t;
         if (t < hsl2rgb_pkg::FX_SIXTH) begin
            r.seg = hsl2rgb_pkg::SEG_RISE;
            r.x   = (t << 2) + (t << 1);
         end else if (t < hsl2rgb_pkg::FX_HALF) begin
            r.seg = hsl2rgb_pkg::SEG_Q;
            r.x   = '0;
         end else if (t < hsl2rgb_pkg::FX_TWO_THIRDS) begin
            r.seg = hsl2rgb_pkg::SEG_FALL;
            r.x   = (y << 2) + (y << 1);
         end else begin
            r.seg = hsl2rgb_pkg::SEG_P;
            r.x   = '0;
         end
         classify = r;
      end
   endfunction

   logic a_ready, b_ready;

   logic                          a_v_ff, a_v_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  a_h_ff, a_h_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  a_s_ff, a_s_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  a_l_ff, a_l_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  a_ls_ff, a_ls_in;
   logic [hsl2rgb_pkg::PROD_W-1:0] ls_prod;

   logic                          b_v_ff, b_v_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  b_p_ff, b_p_in;
   logic [hsl2rgb_pkg::FX_W-1:0]  b_d_ff, b_d_in;
   logic [2:0][hsl2rgb_pkg::FX_W-1:0] b_t_ff, b_t_in;

   logic [hsl2rgb_pkg::FX_W-1:0]  m;
   logic [hsl2rgb_pkg::FX_W:0]    t_up;

   always_comb begin
      b_ready = !b_v_ff || !mid_full;
      a_ready = !a_v_ff || b_ready;
      full    = !a_ready;
   end

   // stage A: saturate, widen, L*S
   always_comb begin
      a_h_in  = widen(req_data.hue);
      a_s_in  = widen(req_data.saturation);
      a_l_in  = widen(req_data.lightness);
      ls_prod = hsl2rgb_pkg::PROD_W'(a_l_in) * hsl2rgb_pkg::PROD_W'(a_s_in);
      a_ls_in = ls_prod[hsl2rgb_pkg::INT_BITS +: hsl2rgb_pkg::FX_W];
      a_v_in  = a_ready ? push : a_v_ff;
   end

   // stage B: P, Q-P and wrapped channel hues
   always_comb begin
      if (a_l_ff < hsl2rgb_pkg::FX_HALF) m = a_ls_ff;
      else m = a_s_ff - a_ls_ff;
      b_p_in = a_l_ff - m;
      b_d_in = hsl2rgb_pkg::FX_W'({m, 1'b0});

      t_up = {1'b0, a_h_ff} + {1'b0, hsl2rgb_pkg::FX_THIRD};
      if (t_up > {1'b0, hsl2rgb_pkg::FX_ONE}) t_up = t_up - {1'b0, hsl2rgb_pkg::FX_ONE};
      b_t_in[0] = t_up[hsl2rgb_pkg::FX_W-1:0];
      b_t_in[1] = a_h_ff;
      if (a_h_ff < hsl2rgb_pkg::FX_THIRD)
         b_t_in[2] = a_h_ff + (hsl2rgb_pkg::FX_ONE - hsl2rgb_pkg::FX_THIRD);
      else
         b_t_in[2] = a_h_ff - hsl2rgb_pkg::FX_THIRD;

      b_v_in = b_ready ? a_v_ff : b_v_ff;
   end

   always_comb begin
      mid_push    = b_v_ff && !mid_full;
      mid_data.p  = b_p_ff;
      mid_data.d  = b_d_ff;
      for (int i = 0; i < 3; i++) mid_data.chan[i] = classify(b_t_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
      if (push && a_ready) begin
         a_h_ff  <= a_h_in;
         a_s_ff  <= a_s_in;
         a_l_ff  <= a_l_in;
         a_ls_ff <= a_ls_in;
      end
      if (a_v_ff && b_ready) begin
         b_p_ff <= b_p_in;
         b_d_ff <= b_d_in;
         b_t_ff <= b_t_in;
      end
   end

endmodule

`default_nettype wire

/* sv/hsl2rgb_queue.sv */
`default_nettype none

module hsl2rgb_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_push,
   output logic                  wr_full,
   input  hsl2rgb_pkg::mid_type  wr_data,
   input  wire                   rd_pop,
   output logic                  rd_empty,
   output hsl2rgb_pkg::mid_type  rd_data
);

   hsl2rgb_pkg::mid_type mem_ff [hsl2rgb_pkg::QUEUE_DEPTH];

   logic [hsl2rgb_pkg::PTR_W-1:0] wptr_ff, wptr_in;
   logic [hsl2rgb_pkg::PTR_W-1:0] rptr_ff, rptr_in;
   logic [hsl2rgb_pkg::CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   always_comb begin
      wr_full  = count_ff == hsl2rgb_pkg::CNT_W'(hsl2rgb_pkg::QUEUE_DEPTH);
      rd_empty = count_ff == '0;
      rd_data  = mem_ff[rptr_ff];
      do_wr    = wr_push && !wr_full;
      do_rd    = rd_pop && !rd_empty;

      wptr_in = wptr_ff;
      if (do_wr) begin
         if (wptr_ff == hsl2rgb_pkg::PTR_W'(hsl2rgb_pkg::QUEUE_DEPTH - 1)) wptr_in = '0;
         else wptr_in = wptr_ff + 1'b1;
      end
      rptr_in = rptr_ff;
      if (do_rd) begin
         if (rptr_ff == hsl2rgb_pkg::PTR_W'(hsl2rgb_pkg::QUEUE_DEPTH - 1)) rptr_in = '0;
         else rptr_in = rptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_wr) mem_ff[wptr_ff] <= wr_data;
   end

endmodule

`default_nettype wire

/* sv/hsl2rgb_back.sv */
`default_nettype none

module hsl2rgb_back (
   input  wire                   clock,
   input  wire                   reset,
   output logic                  mid_pop,
   input  wire                   mid_empty,
   input  hsl2rgb_pkg::mid_type  mid_data,
   output logic                  empty,
   input  wire                   pop,
   output hsl2rgb_pkg::rsp_type  rsp_data
);

   logic mul_ready, out_ready;

   logic                              mul_v_ff, mul_v_in;
   logic [hsl2rgb_pkg::FX_W-1:0]      mul_p_ff;
   logic [2:0][hsl2rgb_pkg::FX_W-1:0] mul_term_ff, mul_term_in;
   logic [2:0][hsl2rgb_pkg::PROD_W-1:0] prod;

   logic                              out_v_ff, out_v_in;
   hsl2rgb_pkg::rsp_type              out_ff, out_in;
   logic [2:0][7:0]                   chan_val;

   logic [hsl2rgb_pkg::FX_W:0]        c;
   logic [hsl2rgb_pkg::SCALE_W-1:0]   scaled;

   always_comb begin
      out_ready = !out_v_ff || pop;
      mul_ready = !mul_v_ff || out_ready;
      mid_pop   = !mid_empty && mul_ready;
      empty     = !out_v_ff;
      rsp_data  = out_ff;
      mul_v_in  = mul_ready ? !mid_empty : mul_v_ff;
      out_v_in  = out_ready ? mul_v_ff : out_v_ff;
   end

   // ramp products per channel
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = hsl2rgb_pkg::PROD_W'(mid_data.d) *
                   hsl2rgb_pkg::PROD_W'(mid_data.chan[i].x);
         case (mid_data.chan[i].seg)
            hsl2rgb_pkg::SEG_RISE,
            hsl2rgb_pkg::SEG_FALL: mul_term_in[i] =
               prod[i][hsl2rgb_pkg::INT_BITS +: hsl2rgb_pkg::FX_W];
            hsl2rgb_pkg::SEG_Q:    mul_term_in[i] = mid_data.d;
            default:               mul_term_in[i] = '0;
         endcase
      end
   end

   // channel = P + term, clamp, times 255, truncate
   always_comb begin
      c      = '0;
      scaled = '0;
      for (int i = 0; i < 3; i++) begin
         c = {1'b0, mul_p_ff} + {1'b0, mul_term_ff[i]};
         if (c > {1'b0, hsl2rgb_pkg::FX_ONE}) c = {1'b0, hsl2rgb_pkg::FX_ONE};
         scaled = (hsl2rgb_pkg::SCALE_W'(c) << 8) - hsl2rgb_pkg::SCALE_W'(c);
         chan_val[i] = scaled[hsl2rgb_pkg::INT_BITS +: 8];
      end
      out_in.red   = chan_val[0];
      out_in.green = chan_val[1];
      out_in.blue  = chan_val[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         mul_v_ff <= mul_v_in;
         out_v_ff <= out_v_in;
      end
      if (mid_pop) begin
         mul_p_ff    <= mid_data.p;
         mul_term_ff <= mul_term_in;
      end
      if (mul_v_ff && out_ready) out_ff <= out_in;
   end

endmodule

`default_nettype wire

/* sv/hsl_to_rgb_pixel_converter.sv */
// HSL to RGB pixel converter.
// Request side: drive req_data and raise push; a request is taken on a clock
// edge with push high and full low. Hue, saturation and lightness are unsigned
// fractions (1 << 16 = 1.0); larger values saturate to 1.0.
// Response side: while empty is low, rsp_data holds the oldest pixel (8-bit
// red, green, blue); it is taken on an edge with pop high and empty low.
// Throughput: one pixel per clock while nothing stalls. The front has one
// multiplier (L*S) and the back one per channel (ramp), each followed by a register.
// A pixel passes stage A, stage B, the queue, the ramp register and the output
// register before it is shown on rsp_data.
// A four-entry queue sits between front and back, so the front keeps taking
// requests while pop is held low; full rises once the queue and the stages are
// occupied, and no pixel is lost or repeated.
// Reset (synchronous, active high) empties every stage and the queue; no
// clearing sequence follows.
`default_nettype none

module hsl_to_rgb_pixel_converter (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  hsl2rgb_pkg::req_type  req_data,
   output logic                  empty,
   input  wire                   pop,
   output hsl2rgb_pkg::rsp_type  rsp_data
);

   logic                 mid_push, mid_full, mid_pop, mid_empty;
   hsl2rgb_pkg::mid_type mid_wr, mid_rd;

   hsl2rgb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .mid_push (mid_push),
      .mid_full (mid_full),
      .mid_data (mid_wr)
   );

   hsl2rgb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (mid_push),
      .wr_full  (mid_full),
      .wr_data  (mid_wr),
      .rd_pop   (mid_pop),
      .rd_empty (mid_empty),
      .rd_data  (mid_rd)
   );

   hsl2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_pop   (mid_pop),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* verif/rgb_pixel_checker.sv */
`timescale 1ns / 100ps

module rgb_pixel_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  hsl2rgb_pkg::req_type req_data,
   input  logic                 empty,
   input  logic                 pop,
   input  hsl2rgb_pkg::rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   pixels_checked,
   output int                   pixels_pending
);

   localparam int    FX_BITS    = 30;
   localparam longint UNIT      = longint'(1) << FX_BITS;
   localparam longint HALF      = UNIT / 2;
   localparam longint THIRD     = UNIT / 3;
   localparam longint SIXTH     = UNIT / 6;
   localparam longint TWO_THIRD = (2 * UNIT) / 3;
   localparam int    MAX_REPORTS = 10;

   hsl2rgb_pkg::rsp_type expected_pixels[$];

   function automatic longint widen_fraction(input logic [16:0] raw);
      longint v;
      v = longint'(raw);
      if (v > (longint'(1) << hsl2rgb_pkg::FRACTION_BITS))
         v = longint'(1) << hsl2rgb_pkg::FRACTION_BITS;
      return v << (FX_BITS - hsl2rgb_pkg::FRACTION_BITS);
   endfunction

   function automatic logic [7:0] ramp_channel(input longint t_in, input longint p,
                                               input longint q);
      longint t;
      longint d;
      longint c;
      longint scaled;
      t = t_in;
      d = q - p;
      if (t < 0)
         t = t + UNIT;
      if (t > UNIT)
         t = t - UNIT;
      if (t < SIXTH)
         c = p + ((d * (6 * t)) >>> FX_BITS);
      else if (t < HALF)
         c = q;
      else if (t < TWO_THIRD)
         c = p + ((d * (6 * (TWO_THIRD - t))) >>> FX_BITS);
      else
         c = p;
      if (c < 0)
         c = 0;
      if (c > UNIT)
         c = UNIT;
      scaled = (c * 255) >>> FX_BITS;
      if (scaled > 255)
         scaled = 255;
      if (scaled < 0)
         scaled = 0;
      return scaled[7:0];
   endfunction

   function automatic hsl2rgb_pkg::rsp_type convert_hsl_pixel(input hsl2rgb_pkg::req_type px);
      longint h;
      longint s;
      longint l;
      longint ls;
      longint q;
      longint p;
      hsl2rgb_pkg::rsp_type rgb;
      h  = widen_fraction(px.hue);
      s  = widen_fraction(px.saturation);
      l  = widen_fraction(px.lightness);
      ls = (l * s) >>> FX_BITS;
      if (l < HALF)
         q = l + ls;
      else
         q = l + s - ls;
      p = 2 * l - q;
      rgb.red   = ramp_channel(h + THIRD, p, q);
      rgb.green = ramp_channel(h, p, q);
      rgb.blue  = ramp_channel(h - THIRD, p, q);
      return rgb;
   endfunction

   initial begin
      mismatch_count = 0;
      pixels_checked = 0;
      pixels_pending = 0;
   end

   always @(posedge clock) begin
      hsl2rgb_pkg::rsp_type want;
      if (!reset) begin
         if (push && !full)
            expected_pixels = {expected_pixels, convert_hsl_pixel(req_data)};
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                           rsp_data.red, rsp_data.green, rsp_data.blue);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked = pixels_checked + 1;
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  if (mismatch_count < MAX_REPORTS)
                     $display({"%0t: pixel mismatch, expected r=%0d g=%0d b=%0d,",
                               " got r=%0d g=%0d b=%0d"},
                              $realtime, want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         pixels_pending = expected_pixels.size();
      end
   end

endmodule

/* verif/hsl_to_rgb_pixel_converter_test.sv */
`timescale 1ns / 100ps

module hsl_to_rgb_pixel_converter_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [16:0] FULL_SCALE = 17'd65536;
   localparam logic [16:0] HALF_SCALE = 17'd32768;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   hsl2rgb_pkg::req_type req_data = '0;
   hsl2rgb_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pixels_checked;
   int pixels_pending;
   int tx_idle_pct = 20;
   int rx_idle_pct = 56;
   int cycle_count = 0;
   int directed_sent = 0;
   int random_sent = 0;

   hsl_to_rgb_pixel_converter DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   rgb_pixel_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pixels_checked (pixels_checked),
      .pixels_pending (pixels_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                  pixels_pending);
         $display("** hsl_to_rgb_pixel_converter: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   function automatic hsl2rgb_pkg::req_type hsl(input logic [16:0] h, input logic [16:0] s,
                                                input logic [16:0] l);
      hsl2rgb_pkg::req_type px;
      px.hue        = h;
      px.saturation = s;
      px.lightness  = l;
      return px;
   endfunction

   function automatic logic [16:0] random_fraction();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return 17'($urandom_range(0, 17'h1FFFF));
      else if (pick < 20) begin
         case ($urandom_range(0, 3))
            0: return 17'd0;
            1: return FULL_SCALE;
            2: return HALF_SCALE;
            default: return HALF_SCALE - 17'd1;
         endcase
      end
      return 17'($urandom_range(0, 65536));
   endfunction

   task automatic send_pixel(input hsl2rgb_pkg::req_type px);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      push <= 1'b0;
      @(negedge clock);
      while (pixels_pending != 0)
         @(negedge clock);
   endtask

   hsl2rgb_pkg::req_type directed[$];

   initial begin
      directed = '{
         hsl(17'd0, 17'd0, 17'd0),
         hsl(17'h1FFFF, 17'h1FFFF, 17'h1FFFF),
         hsl(FULL_SCALE, FULL_SCALE, FULL_SCALE),
         hsl(FULL_SCALE, FULL_SCALE, HALF_SCALE),
         hsl(17'd0, FULL_SCALE, HALF_SCALE),
         hsl(17'd10922, FULL_SCALE, HALF_SCALE),
         hsl(17'd10923, FULL_SCALE, HALF_SCALE),
         hsl(17'd21845, FULL_SCALE, HALF_SCALE),
         hsl(17'd21846, FULL_SCALE, HALF_SCALE),
         hsl(HALF_SCALE, FULL_SCALE, HALF_SCALE),
         hsl(17'd43690, FULL_SCALE, HALF_SCALE),
         hsl(17'd43691, FULL_SCALE, HALF_SCALE),
         hsl(17'd54613, FULL_SCALE, HALF_SCALE),
         hsl(17'd65535, FULL_SCALE, HALF_SCALE),
         hsl(17'd65537, FULL_SCALE, HALF_SCALE),
         hsl(17'd30000, 17'd0, 17'd40000),
         hsl(17'd30000, 17'd40000, 17'd32767),
         hsl(17'd30000, 17'd40000, HALF_SCALE),
         hsl(17'd30000, 17'd40000, 17'd32769),
         hsl(17'd5000, FULL_SCALE, 17'd0),
         hsl(17'd5000, FULL_SCALE, FULL_SCALE),
         hsl(17'd5000, 17'h10001, 17'd20000),
         hsl(17'd5000, 17'd20000, 17'h1FFFF),
         hsl(17'h1FFFF, 17'd0, 17'd0),
         hsl(17'd0, 17'h1FFFF, 17'd12345)
      };

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // phase 0: sender idles lightly, receiver stalls often
      foreach (directed[i]) begin
         send_pixel(directed[i]);
         directed_sent++;
      end
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
         send_pixel(hsl(random_fraction(), random_fraction(), random_fraction()));
         random_sent++;
      end

      // hold off the sender until the pipeline is empty
      wait_for_drain();
      tx_idle_pct = 56;
      rx_idle_pct = 20;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
         send_pixel(hsl(random_fraction(), random_fraction(), random_fraction()));
         random_sent++;
      end

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (random_sent < RANDOM_ITEMS) begin
         send_pixel(hsl(random_fraction(), random_fraction(), random_fraction()));
         random_sent++;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d directed and %0d random HSL pixels under three flow-control mixes;",
               directed_sent, random_sent);
      $display("%0d RGB results compared, %0d mismatches.", pixels_checked, mismatch_count);
      if (mismatch_count == 0 && pixels_pending == 0)
         $display("** hsl_to_rgb_pixel_converter: PASSED **");
      else
         $display("** hsl_to_rgb_pixel_converter: FAILED **");
      $finish;
   end

endmodule
